[src/gld_pkg.sv]
// Shared types and constants of the GIF LZW pixel decoder.
// Used by the front queue, the decode engine and the top level.
package gld_pkg;

    localparam int CODE_W     = 12;  // widest LZW code
    localparam int SYM_W      = 8;   // palette index
    localparam int BUF_W      = 20;  // bit buffer
    localparam int CNT_W      = 5;   // bits held in the bit buffer
    localparam int ADDR_W     = 24;  // destination pixel address
    localparam int OUT_W      = 40;  // packed result, padded to whole bytes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_ROOT   = 11;  // largest legal minimum code size

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_INDEX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_ENABLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLACE    = 3'd7;

    typedef enum logic {
        ITEM_BYTE = 1'b0,
        ITEM_TICK = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [SYM_W-1:0]  data;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [11:0]      frame_x;
        logic [11:0]      frame_y;
        logic [12:0]      frame_w;
        logic [12:0]      frame_h;
        logic [12:0]      image_width;
        logic [SYM_W-1:0] trans_index;
        logic             trans_enable;
        logic             interlace;
    } cfg_t;

endpackage

[src/gld_front.sv]
// Front queue of the GIF LZW pixel decoder: accepts and classifies items.
// Two-entry queue toward the decode engine; depends on gld_pkg.
module gld_front import gld_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // data_byte
    input  logic             s_tuser,   // command
    input  logic             s_tlast,   // last_byte
    output logic             q_valid,
    output item_t            q_item,
    input  logic             q_take
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    item_t       item_in;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        item_in.kind = s_tuser ? ITEM_TICK : ITEM_BYTE;
        item_in.data = s_tdata;
        item_in.last = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= item_in;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_take && q_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !(q_take && q_valid)) begin
                count_reg <= count_reg + 2'd1;
            end else if (!push && q_take && q_valid) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[src/gld_engine.sv]
// Decode engine of the GIF LZW pixel decoder: code unpacking, dictionary walk,
// pixel stack, frame placement and the result register. Depends on gld_pkg.
module gld_engine import gld_pkg::*; #(
    parameter int DICT_SIZE   = 4096,
    parameter int STACK_DEPTH = 8192
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int DAW   = $clog2(DICT_SIZE);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int TOP_W = SAW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DRAIN, S_CODE, S_RD, S_RDW,
        S_POP1, S_ILACE, S_POP2, S_POP3, S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        PH_MINSIZE, PH_LENGTH, PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN, ST_DONE, ST_ERR
    } stop_t;

    logic [CODE_W-1:0] prefix_mem [DICT_SIZE];
    logic [SYM_W-1:0]  suffix_mem [DICT_SIZE];
    logic [SYM_W-1:0]  stack_mem  [STACK_DEPTH];

    state_t             state_reg;
    phase_t             phase_reg;
    stop_t              stopped_reg;
    logic [TOP_W-1:0]   top_reg;
    logic [BUF_W-1:0]   bitbuf_reg;
    logic [CNT_W-1:0]   bitcnt_reg;
    logic [3:0]         root_reg;
    logic [3:0]         cw_reg;
    logic [12:0]        nfc_reg;
    logic [CODE_W-1:0]  prev_reg;
    logic               prev_valid_reg;
    logic [SYM_W-1:0]   first_reg;
    logic [7:0]         bbl_reg;
    logic               input_ended_reg;
    logic [24:0]        pd_reg;
    logic [12:0]        curx_reg;
    logic [13:0]        currow_reg;
    logic [3:0]         step_reg;
    logic [2:0]         pass_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [CODE_W-1:0]  incode_reg;
    logic [CODE_W-1:0]  walk_reg;
    logic               mode_first_reg;
    logic [SYM_W-1:0]   pix_reg;
    logic               inframe_reg;
    logic [ADDR_W-1:0]  prod_reg;
    logic [25:0]        total_reg;
    logic               pv_reg;
    logic               we_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [SYM_W-1:0]   color_reg;
    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;

    logic [CODE_W-1:0]  pre_q_reg;
    logic [SYM_W-1:0]   suf_q_reg;
    logic [SYM_W-1:0]   stk_q_reg;

    logic [12:0]        clear_code;
    logic [12:0]        width_mask;
    logic [12:0]        nfc_inc;
    logic [13:0]        endx;
    logic [13:0]        endy;
    logic               wants;
    logic               stack_full;
    logic               in_frame;
    logic [SYM_W-1:0]   sym;
    logic [SAW-1:0]     stk_rd_addr;
    logic [26:0]        row_prod;

    assign clear_code  = 13'd1 << root_reg;
    assign width_mask  = (13'd1 << cw_reg) - 13'd1;
    assign nfc_inc     = nfc_reg + 13'd1;
    assign endx        = 14'(cfg.frame_x) + 14'(cfg.frame_w);
    assign endy        = 14'(cfg.frame_y) + 14'(cfg.frame_h);
    assign wants       = (stopped_reg == ST_RUN) && (top_reg == '0) &&
                         ((phase_reg == PH_MINSIZE) || (bitcnt_reg < CNT_W'(cw_reg)));
    assign stack_full  = (top_reg >= TOP_W'(STACK_DEPTH));
    assign in_frame    = (currow_reg < endy) && (14'(curx_reg) < endx);
    // root codes are their own suffix, so the root entries are never stored
    assign sym         = (13'(walk_reg) < clear_code) ? walk_reg[SYM_W-1:0] : suf_q_reg;
    assign stk_rd_addr = SAW'(top_reg - TOP_W'(1));
    assign row_prod    = currow_reg * cfg.image_width;

    assign q_take   = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        pre_q_reg <= prefix_mem[walk_reg[DAW-1:0]];
        suf_q_reg <= suffix_mem[walk_reg[DAW-1:0]];
        stk_q_reg <= stack_mem[stk_rd_addr];
        total_reg <= cfg.frame_w * cfg.frame_h;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_MINSIZE;
            stopped_reg     <= ST_RUN;
            top_reg         <= '0;
            bitbuf_reg      <= '0;
            bitcnt_reg      <= '0;
            root_reg        <= '0;
            cw_reg          <= '0;
            nfc_reg         <= '0;
            prev_reg        <= '0;
            prev_valid_reg  <= 1'b0;
            first_reg       <= '0;
            bbl_reg         <= '0;
            input_ended_reg <= 1'b0;
            pd_reg          <= '0;
            curx_reg        <= '0;
            currow_reg      <= '0;
            step_reg        <= 4'd1;
            pass_reg        <= 3'd1;
            m_valid_reg     <= 1'b0;
        end else begin
            // S_RESULT owns the result register while it is there
            if (m_tready && state_reg != S_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        pv_reg    <= 1'b0;
                        we_reg    <= 1'b0;
                        addr_reg  <= '0;
                        color_reg <= '0;
                        if (q_item.kind == ITEM_TICK) begin
                            if (stopped_reg == ST_RUN && top_reg != '0) begin
                                state_reg <= S_POP1;
                            end else begin
                                state_reg <= S_RESULT;
                            end
                        end else if (!wants) begin
                            state_reg <= S_RESULT;   // drop unwanted byte
                        end else begin
                            if (q_item.last) begin
                                input_ended_reg <= 1'b1;
                            end
                            state_reg <= S_DRAIN;
                            unique case (phase_reg)
                                PH_MINSIZE: begin
                                    if (q_item.data > SYM_W'(MAX_ROOT) ||
                                        (13'd1 << q_item.data[3:0]) >= 13'(DICT_SIZE)) begin
                                        stopped_reg <= ST_ERR;
                                        top_reg     <= '0;
                                    end else begin
                                        root_reg       <= q_item.data[3:0];
                                        cw_reg         <= q_item.data[3:0] + 4'd1;
                                        nfc_reg        <= (13'd1 << q_item.data[3:0]) + 13'd2;
                                        prev_valid_reg <= 1'b0;
                                        prev_reg       <= '0;
                                        first_reg      <= '0;
                                        bitbuf_reg     <= '0;
                                        bitcnt_reg     <= '0;
                                        bbl_reg        <= '0;
                                        phase_reg      <= PH_LENGTH;
                                        curx_reg       <= 13'(cfg.frame_x);
                                        currow_reg     <= 14'(cfg.frame_y);
                                        step_reg       <= cfg.interlace ? 4'd8 : 4'd1;
                                        pass_reg       <= 3'd1;
                                        pd_reg         <= '0;
                                        if (total_reg == '0) begin
                                            stopped_reg <= ST_DONE;
                                            top_reg     <= '0;
                                        end
                                    end
                                end
                                PH_LENGTH: begin
                                    if (q_item.data == '0) begin
                                        stopped_reg <= ST_DONE;
                                        top_reg     <= '0;
                                    end else begin
                                        bbl_reg   <= q_item.data;
                                        phase_reg <= PH_DATA;
                                    end
                                end
                                default: begin
                                    bitbuf_reg <= bitbuf_reg | (BUF_W'(q_item.data) << bitcnt_reg);
                                    bitcnt_reg <= bitcnt_reg + CNT_W'(8);
                                    bbl_reg    <= bbl_reg - 8'd1;
                                    if (bbl_reg == 8'd1) begin
                                        phase_reg <= PH_LENGTH;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_DRAIN: begin
                    if (stopped_reg == ST_RUN && top_reg == '0 && phase_reg != PH_MINSIZE &&
                        bitcnt_reg >= CNT_W'(cw_reg)) begin
                        code_reg   <= bitbuf_reg[CODE_W-1:0] & width_mask[CODE_W-1:0];
                        bitbuf_reg <= bitbuf_reg >> cw_reg;
                        bitcnt_reg <= bitcnt_reg - CNT_W'(cw_reg);
                        state_reg  <= S_CODE;
                    end else begin
                        if (input_ended_reg && wants) begin
                            stopped_reg <= ST_DONE;   // input ran out
                            top_reg     <= '0;
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_CODE: begin
                    state_reg <= S_DRAIN;
                    if (13'(code_reg) >= 13'(DICT_SIZE) ||
                        13'(code_reg) == clear_code + 13'd1) begin
                        stopped_reg <= ST_DONE;
                        top_reg     <= '0;
                    end else if (13'(code_reg) == clear_code) begin
                        cw_reg         <= root_reg + 4'd1;
                        nfc_reg        <= clear_code + 13'd2;
                        prev_valid_reg <= 1'b0;
                    end else if (!prev_valid_reg) begin
                        walk_reg       <= code_reg;
                        mode_first_reg <= 1'b1;
                        state_reg      <= S_RD;
                    end else begin
                        mode_first_reg <= 1'b0;
                        incode_reg     <= code_reg;
                        if (13'(code_reg) >= nfc_reg) begin
                            // code not yet in the dictionary: repeat first symbol
                            if (stack_full) begin
                                stopped_reg <= ST_ERR;
                                top_reg     <= '0;
                            end else begin
                                stack_mem[top_reg[SAW-1:0]] <= first_reg;
                                top_reg   <= top_reg + TOP_W'(1);
                                walk_reg  <= prev_reg;
                                state_reg <= S_RD;
                            end
                        end else begin
                            walk_reg  <= code_reg;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    state_reg <= S_RDW;
                end
                S_RDW: begin
                    if (mode_first_reg) begin
                        first_reg      <= sym;
                        stack_mem[top_reg[SAW-1:0]] <= sym;
                        top_reg        <= top_reg + TOP_W'(1);
                        prev_reg       <= code_reg;
                        prev_valid_reg <= 1'b1;
                        state_reg      <= S_DRAIN;
                    end else if (stack_full) begin
                        stopped_reg <= ST_ERR;
                        top_reg     <= '0;
                        state_reg   <= S_DRAIN;
                    end else begin
                        stack_mem[top_reg[SAW-1:0]] <= sym;
                        top_reg <= top_reg + TOP_W'(1);
                        if (13'(walk_reg) > clear_code) begin
                            walk_reg  <= pre_q_reg;
                            state_reg <= S_RD;
                        end else begin
                            first_reg <= sym;
                            if (nfc_reg < 13'(DICT_SIZE)) begin
                                prefix_mem[nfc_reg[DAW-1:0]] <= prev_reg;
                                suffix_mem[nfc_reg[DAW-1:0]] <= sym;
                                nfc_reg <= nfc_inc;
                                if (nfc_inc >= (13'd1 << cw_reg) &&
                                    nfc_inc < 13'(DICT_SIZE)) begin
                                    cw_reg <= cw_reg + 4'd1;
                                end
                            end
                            prev_reg  <= incode_reg;
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_POP1: begin
                    if (14'(curx_reg) == endx) begin
                        curx_reg   <= 13'(cfg.frame_x);
                        currow_reg <= currow_reg + 14'(step_reg);
                        state_reg  <= cfg.interlace ? S_ILACE : S_POP2;
                    end else begin
                        state_reg <= S_POP2;
                    end
                end
                S_ILACE: begin
                    // advance one interlace pass per cycle until the row fits
                    if (currow_reg >= endy && pass_reg < 3'd5) begin
                        pass_reg <= pass_reg + 3'd1;
                        case (pass_reg)
                            3'd1: currow_reg <= 14'(cfg.frame_y) + 14'd4;
                            3'd2: begin
                                currow_reg <= 14'(cfg.frame_y) + 14'd2;
                                step_reg   <= 4'd4;
                            end
                            3'd3: begin
                                currow_reg <= 14'(cfg.frame_y) + 14'd1;
                                step_reg   <= 4'd2;
                            end
                            default: begin
                                currow_reg <= 14'(cfg.frame_y);
                                step_reg   <= 4'd1;
                            end
                        endcase
                    end else begin
                        state_reg <= S_POP2;
                    end
                end
                S_POP2: begin
                    pix_reg     <= stk_q_reg;
                    top_reg     <= top_reg - TOP_W'(1);
                    inframe_reg <= in_frame;
                    prod_reg    <= row_prod[ADDR_W-1:0];
                    pd_reg      <= pd_reg + 25'd1;
                    state_reg   <= S_POP3;
                end
                S_POP3: begin
                    pv_reg    <= 1'b1;
                    color_reg <= pix_reg;
                    if (inframe_reg) begin
                        addr_reg <= ADDR_W'(curx_reg) + prod_reg;
                        we_reg   <= !(cfg.trans_enable && pix_reg == cfg.trans_index);
                        curx_reg <= curx_reg + 13'd1;
                    end
                    if (26'(pd_reg) >= total_reg) begin
                        stopped_reg <= ST_DONE;
                        top_reg     <= '0;
                        state_reg   <= S_RESULT;
                    end else if (top_reg == '0) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000,
                                        stopped_reg == ST_ERR,
                                        stopped_reg == ST_DONE,
                                        wants, color_reg, addr_reg, we_reg, pv_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[src/gif_lzw_pixel_decoder_core.sv]
// Top level of the GIF LZW pixel decoder: configuration registers, front queue
// and decode engine. Depends on gld_pkg, gld_front and gld_engine.
//
// Usage: s_ carries one item per beat: s_tuser = 0 for a stream byte in
// s_tdata (minimum code size, then length-prefixed sub-blocks, s_tlast on the
// final byte available), s_tuser = 1 for an output tick that pops one pixel.
// Every accepted item gives exactly one result on m_, in order.
// Frame registers are written through cfg_wr_en/cfg_index/cfg_wdata between
// images, while no item is in flight.
// Sequence: a tick passes the queue, the take, the row wrap, the stack read
// and the address load before its result; with interlace a row wrap also
// passes S_ILACE, which skips one pass per step. A stream byte that completes
// no code goes from S_IDLE through S_DRAIN to the result; each code it
// completes adds S_CODE and a dictionary read (S_RD, S_RDW) per symbol pushed,
// and a tick that empties the stack decodes waiting codes the same way. The
// walk is bounded by the registered dictionary read, one chain link per
// S_RD/S_RDW pair. Chain walks are paid once per code and spread over the
// pixels they push. The engine takes a new item only once it has issued the result of the last one.
// A two-entry queue takes items while the engine works; the result register
// holds a result until m_tready, and the engine stalls only at its next result.
// Reset (aresetn low, synchronous) restores the register defaults and the
// waiting-for-code-size state; dictionary and stack need no clearing.
module gif_lzw_pixel_decoder_core import gld_pkg::*; #(
    parameter int DICT_SIZE   = 4096,
    parameter int STACK_DEPTH = 8192
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic                  s_tuser,   // command
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_valid, write_enable, pixel_address[23:0], color_index[7:0],
    // need_byte, done_res, error, zero padding
    output logic [OUT_W-1:0]      m_tdata
);

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_x      <= '0;
            cfg_reg.frame_y      <= '0;
            cfg_reg.frame_w      <= 13'd1;
            cfg_reg.frame_h      <= 13'd1;
            cfg_reg.image_width  <= 13'd1;
            cfg_reg.trans_index  <= '0;
            cfg_reg.trans_enable <= 1'b0;
            cfg_reg.interlace    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_X:      cfg_reg.frame_x      <= cfg_wdata[11:0];
                CFG_FRAME_Y:      cfg_reg.frame_y      <= cfg_wdata[11:0];
                CFG_FRAME_W:      cfg_reg.frame_w      <= cfg_wdata;
                CFG_FRAME_H:      cfg_reg.frame_h      <= cfg_wdata;
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                CFG_TRANS_INDEX:  cfg_reg.trans_index  <= cfg_wdata[7:0];
                CFG_TRANS_ENABLE: cfg_reg.trans_enable <= cfg_wdata[0];
                CFG_INTERLACE:    cfg_reg.interlace    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    gld_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take)
    );

    gld_engine #(
        .DICT_SIZE   (DICT_SIZE),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[src/gld_checker.sv]
// Port-level checks of the GIF LZW pixel decoder result channel.
// Bound to gif_lzw_pixel_decoder_core; depends on gld_pkg.
module gld_checker import gld_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_stop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[35] && m_tdata[36]))
        else $error("done and error both set");

    a_we_pix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("write enable without a popped pixel");

    a_nopix_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[33:2] == '0)
        else $error("pixel fields set without a popped pixel");

    a_need_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> !m_tdata[35] && !m_tdata[36])
        else $error("byte requested after stop");

endmodule

bind gif_lzw_pixel_decoder_core gld_checker u_gld_checker (.*);

[tb/sv/tb.sv]
// Self-checking bench for gif_lzw_pixel_decoder_core: builds a legal LZW code stream,
// mixes it with output ticks and junk items, and checks every result against a predictor.
// Depends on gld_pkg and the RTL of the decoder.
module tb;
    import gld_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {WAIT_SIZE, WAIT_LEN, IN_BLOCK} stream_phase_e;
    typedef enum int {RUNNING, DONE_OK, FAULT} halt_e;

    typedef struct {
        bit        pv;
        bit        we;
        bit [23:0] addr;
        bit [7:0]  color;
        bit        need;
        bit        done;
        bit        err;
    } pixel_out_t;

    class pixel_scoreboard;
        int unsigned fx, fy, fw, fh, iw, ti, te, il;
        bit [11:0] prefix_tab[4096];
        bit [7:0]  suffix_tab[4096];
        bit [7:0]  stack_mem[8192];
        int unsigned top, bbuf, bcnt, root, cw, nfree, prevc, firsts, blk_left;
        int unsigned pdone, cx, crow, rstep, passn;
        stream_phase_e phase;
        halt_e halted;
        bit prev_ok, in_ended;
        pixel_out_t expected_q[$];
        int errors, popped, writes, results;

        function new();
            fx = 0; fy = 0; fw = 1; fh = 1; iw = 1; ti = 0; te = 0; il = 0;
            top = 0; bbuf = 0; bcnt = 0; root = 0; cw = 0; nfree = 0; prevc = 0;
            firsts = 0; blk_left = 0; pdone = 0; phase = WAIT_SIZE; halted = RUNNING;
            prev_ok = 0; in_ended = 0;
            errors = 0; popped = 0; writes = 0; results = 0;
            place_init();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
            case (idx)
                CFG_FRAME_X:      fx = v & 12'hfff;
                CFG_FRAME_Y:      fy = v & 12'hfff;
                CFG_FRAME_W:      fw = v & 13'h1fff;
                CFG_FRAME_H:      fh = v & 13'h1fff;
                CFG_IMAGE_WIDTH:  iw = v & 13'h1fff;
                CFG_TRANS_INDEX:  ti = v & 8'hff;
                CFG_TRANS_ENABLE: te = v & 1;
                default:          il = v & 1;
            endcase
        endfunction

        function void place_init();
            cx = fx;
            crow = fy;
            rstep = il ? 8 : 1;
            passn = 1;
        endfunction

        function void halt(halt_e how);
            halted = how;
            top = 0;
        endfunction

        function bit push(int unsigned v);
            if (top >= 8192) begin
                halt(FAULT);
                return 0;
            end
            stack_mem[top] = v[7:0];
            top++;
            return 1;
        endfunction

        function bit wants_byte();
            return halted == RUNNING && top == 0 && (phase == WAIT_SIZE || bcnt < cw);
        endfunction

        function void run_code(int unsigned code);
            int unsigned clr, in_code, c;
            clr = 1 << root;
            if (code >= 4096 || code == clr + 1) begin
                halt(DONE_OK);
                return;
            end
            if (code == clr) begin
                cw = root + 1;
                nfree = clr + 2;
                prev_ok = 0;
                return;
            end
            if (!prev_ok) begin
                firsts = suffix_tab[code];
                void'(push(firsts));
                prevc = code;
                prev_ok = 1;
                return;
            end
            in_code = code;
            c = code;
            if (c >= nfree) begin
                if (!push(firsts)) return;
                c = prevc;
            end
            while (c > clr) begin
                if (!push(suffix_tab[c])) return;
                c = prefix_tab[c];
            end
            firsts = suffix_tab[c];
            if (!push(firsts)) return;
            if (nfree < 4096) begin
                prefix_tab[nfree] = prevc[11:0];
                suffix_tab[nfree] = firsts[7:0];
                nfree++;
                if (nfree >= (1 << cw) && nfree < 4096) cw++;
            end
            prevc = in_code;
        endfunction

        function void drain();
            int unsigned code;
            while (halted == RUNNING && top == 0 && phase != WAIT_SIZE && bcnt >= cw) begin
                code = bbuf & ((1 << cw) - 1);
                bbuf = bbuf >> cw;
                bcnt = bcnt - cw;
                run_code(code);
            end
            if (in_ended && wants_byte()) halt(DONE_OK);
        endfunction

        function void start_image(int unsigned ds);
            int unsigned clr;
            if (ds > 11 || (1 << ds) >= 4096) begin
                halt(FAULT);
                return;
            end
            clr = 1 << ds;
            for (int unsigned k = 0; k < clr; k++) begin
                prefix_tab[k] = 0;
                suffix_tab[k] = k[7:0];
            end
            root = ds;
            cw = ds + 1;
            nfree = clr + 2;
            prev_ok = 0;
            prevc = 0;
            firsts = 0;
            bbuf = 0;
            bcnt = 0;
            blk_left = 0;
            phase = WAIT_LEN;
            place_init();
            pdone = 0;
            if (fw * fh == 0) halt(DONE_OK);
        endfunction

        function void pop_pixel(ref pixel_out_t r);
            int unsigned endx, endy;
            bit [7:0] pix;
            endx = fx + fw;
            endy = fy + fh;
            if (cx == endx) begin
                cx = fx;
                crow += rstep;
                if (il) begin
                    while (crow >= endy && passn < 5) begin
                        passn++;
                        case (passn)
                            2: crow = fy + 4;
                            3: begin
                                crow = fy + 2;
                                rstep = 4;
                            end
                            4: begin
                                crow = fy + 1;
                                rstep = 2;
                            end
                            default: begin
                                crow = fy;
                                rstep = 1;
                            end
                        endcase
                    end
                end
            end
            top--;
            pix = stack_mem[top];
            pdone++;
            popped++;
            r.pv = 1;
            r.color = pix;
            if (crow < endy && cx < endx) begin
                r.addr = 24'(cx + crow * iw);
                r.we = !(te && pix == ti);
                writes += r.we;
                cx++;
            end
            if (pdone >= fw * fh) halt(DONE_OK);
            else if (top == 0) drain();
        endfunction

        // Advance the predictor by one accepted item and queue what it must produce.
        function void note_input(item_kind_t kind, bit [7:0] data, bit last);
            pixel_out_t r;
            r = '{default: 0};
            if (kind == ITEM_TICK) begin
                if (halted == RUNNING && top > 0) pop_pixel(r);
            end else if (wants_byte()) begin
                if (last) in_ended = 1;
                if (phase == WAIT_SIZE) begin
                    start_image(data);
                end else if (phase == WAIT_LEN) begin
                    if (data == 0) halt(DONE_OK);
                    else begin
                        blk_left = data;
                        phase = IN_BLOCK;
                    end
                end else begin
                    bbuf = bbuf | (int'(data) << bcnt);
                    bcnt += 8;
                    blk_left--;
                    if (blk_left == 0) phase = WAIT_LEN;
                end
                if (halted == RUNNING) drain();
            end
            r.need = wants_byte();
            r.done = halted == DONE_OK;
            r.err = halted == FAULT;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        endtask

        task check_result(logic [OUT_W-1:0] t);
            pixel_out_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("result 0x%0h with nothing expected", t));
                return;
            end
            e = expected_q.pop_front();
            results++;
            check_field("pixel_valid", 32'(t[0]), 32'(e.pv));
            check_field("write_enable", 32'(t[1]), 32'(e.we));
            check_field("pixel_address", 32'(t[25:2]), 32'(e.addr));
            check_field("color_index", 32'(t[33:26]), 32'(e.color));
            check_field("need_byte", 32'(t[34]), 32'(e.need));
            check_field("done", 32'(t[35]), 32'(e.done));
            check_field("error", 32'(t[36]), 32'(e.err));
            check_field("padding", 32'(t[OUT_W-1:37]), 32'd0);
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;

    pixel_scoreboard sb = new();

    // code stream generator state
    int unsigned gen_ds, gen_clear, gen_next, gen_w, acc, acc_n, blk_rem;
    int          end_bits;
    bit          gen_prev_ok, size_sent, gen_finish, end_queued, last_marked;
    int          burst_left, n_items, hold_cycles;
    bit          hold_req;

    gif_lzw_pixel_decoder_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Receiver: alternate ready runs and short stalls; honor a long hold when asked.
    initial begin
        bit rdy;
        int cnt;
        m_tready = 1'b0;
        rdy = 0;
        cnt = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cycles = 400;
                m_tready <= 1'b0;
            end else begin
                if (cnt == 0) begin
                    rdy = !rdy;
                    cnt = rdy ? $urandom_range(1, 40) : $urandom_range(1, 6);
                end
                cnt--;
                m_tready <= rdy;
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout waiting for the decoder");
        $display("FAIL gif_lzw_pixel_decoder_core");
        $finish;
    end

    // Append one code at the current width, tracking the dictionary the decoder builds.
    function automatic void add_code();
        int unsigned code;
        bit first_code;
        if (gen_finish && !end_queued) begin
            code = gen_clear + 1;
            acc |= code << acc_n;
            acc_n += gen_w;
            end_queued = 1;
            end_bits = acc_n;
            return;
        end
        if (end_queued) begin
            acc_n += 8;
            return;
        end
        // the first code after a clear adds no dictionary entry
        first_code = !gen_prev_ok;
        if (first_code) begin
            code = $urandom_range(0, gen_clear - 1);
            gen_prev_ok = 1;
        end else if ($urandom_range(0, 99) < 2) begin
            code = gen_clear;
        end else begin
            code = $urandom_range(0, gen_next < 4096 ? gen_next : 4095);
            if (code == gen_clear || code == gen_clear + 1) code = $urandom_range(0, gen_clear - 1);
        end
        acc |= code << acc_n;
        acc_n += gen_w;
        if (code == gen_clear) begin
            gen_w = gen_ds + 1;
            gen_next = gen_clear + 2;
            gen_prev_ok = 0;
        end else if (gen_next < 4096 && code != gen_clear + 1 && !first_code) begin
            gen_next++;
            if (gen_next >= (1 << gen_w) && gen_next < 4096) gen_w++;
        end
    endfunction

    function automatic void next_stream_byte(output logic [7:0] data, output logic last);
        last = 0;
        if (!size_sent) begin
            size_sent = 1;
            data = gen_ds[7:0];
            return;
        end
        if (blk_rem == 0) begin
            blk_rem = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 255);
            data = blk_rem[7:0];
            return;
        end
        while (acc_n < 8) add_code();
        data = acc[7:0];
        acc = acc >> 8;
        acc_n -= 8;
        blk_rem--;
        if (end_queued && !last_marked) begin
            end_bits -= 8;
            if (end_bits <= 0) begin
                last = 1;
                last_marked = 1;
            end
        end
    endfunction

    task automatic send_item(input item_kind_t kind, input logic [7:0] data, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, data, last);
        n_items++;
    endtask

    // Pick the next item from what the decoder wants right now.
    task automatic send_next();
        logic [7:0] d;
        logic l;
        if (sb.halted != RUNNING) begin
            send_item(item_kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
        end else if (sb.wants_byte()) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(ITEM_TICK, 8'($urandom_range(0, 255)), 1'b0);
            end else begin
                next_stream_byte(d, l);
                send_item(ITEM_BYTE, d, l);
            end
        end else if ($urandom_range(0, 3) == 0) begin
            // drop: the decoder ignores bytes while it still holds pixels
            send_item(ITEM_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            send_item(ITEM_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_items(int n, int unsigned pix_cap);
        for (int i = 0; i < n && sb.pdone < pix_cap; i++) send_next();
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v[CFG_DATA_W-1:0];
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        hold_req = 0;
        hold_cycles = 0;
        burst_left = 0;
        n_items = 0;
        gen_ds = $urandom_range(2, 8);
        gen_clear = 1 << gen_ds;
        gen_w = gen_ds + 1;
        gen_next = gen_clear + 2;
        gen_prev_ok = 0;
        acc = gen_clear;  // open the stream with a clear code
        acc_n = gen_w;
        blk_rem = 0;
        size_sent = 0;
        gen_finish = 0;
        end_queued = 0;
        last_marked = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // small interlaced frame, wide stride, transparency on
        write_reg(CFG_FRAME_X, 5);
        write_reg(CFG_FRAME_Y, 3);
        write_reg(CFG_FRAME_W, 3);
        write_reg(CFG_FRAME_H, 20);
        write_reg(CFG_IMAGE_WIDTH, 4096);
        write_reg(CFG_TRANS_INDEX, $urandom_range(0, gen_clear - 1));
        write_reg(CFG_TRANS_ENABLE, 1);
        write_reg(CFG_INTERLACE, 1);

        // opening items: tick on empty stack, usually the code size, tick before any code
        send_item(ITEM_TICK, 8'hff, 1'b1);
        send_next();
        send_item(ITEM_TICK, 8'h00, 1'b0);
        run_items(200, 45);
        settle();

        write_reg(CFG_FRAME_H, 4096);
        write_reg(CFG_IMAGE_WIDTH, 1);
        write_reg(CFG_TRANS_INDEX, 0);
        hold_req = 1;
        run_items(300, 32'hffff_ffff);
        settle();

        write_reg(CFG_FRAME_X, 4095);
        write_reg(CFG_FRAME_Y, 4095);
        write_reg(CFG_FRAME_W, 4096);
        write_reg(CFG_IMAGE_WIDTH, 4096);
        write_reg(CFG_TRANS_INDEX, 255);
        write_reg(CFG_TRANS_ENABLE, 0);
        write_reg(CFG_INTERLACE, 0);
        run_items(400, 32'hffff_ffff);

        // close the stream with an end code, then items after the stop
        gen_finish = 1;
        for (int i = 0; i < 20000 && sb.halted == RUNNING; i++) send_next();
        repeat (12) send_next();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("%0d items, %0d results, root size %0d, %0d dictionary codes in use",
            n_items, sb.results, gen_ds, sb.nfree);
        $display("%0d pixels popped, %0d frame writes, decoder %s, %0d mismatches",
            sb.popped, sb.writes, sb.halted == DONE_OK ? "stopped on end code" : "not stopped",
            sb.errors);
        if (sb.errors == 0) begin
            $display("PASS gif_lzw_pixel_decoder_core");
        end else begin
            $display("FAIL gif_lzw_pixel_decoder_core");
        end
        $finish;
    end
endmodule
